@@ sv/cce_pkg.sv @@
// Shared types and constants for the control character escaper.
// Used by the front, queue, back and top level modules; no dependencies.
package cce_pkg;

  localparam int MAX_BUFFER = 4096;
  localparam int CNT_W      = $clog2(MAX_BUFFER);
  localparam int BSIZE_W    = 13;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  localparam logic [BSIZE_W-1:0] BSIZE_RESET = BSIZE_W'(512);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CTRL_OFS = 8'h40;
  localparam int         ESC_LEN  = 4;

  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            eos;
  } job_t;

  function automatic logic [3:0][7:0] dec_digits(input logic [7:0] b);
    logic [1:0]  h;
    logic [6:0]  r;
    logic [14:0] prod;
    logic [3:0]  t;
    logic [3:0]  o;
    logic [3:0][7:0] d;
    h    = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
    r    = 7'(b - 8'(h) * 8'd100);
    prod = 15'(r) * 15'd205;
    t    = prod[14:11];
    o    = 4'(r - 7'(t) * 7'd10);
    d[0] = CH_BSL;
    d[1] = CH_ZERO + 8'(h);
    d[2] = CH_ZERO + 8'(t);
    d[3] = CH_ZERO + 8'(o);
    return d;
  endfunction

endpackage

@@ sv/cce_front.sv @@
// Front end: capacity register, written count and byte classification.
// Depends on cce_pkg; emits one job per accepted byte that gives output.
module cce_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [cce_pkg::BSIZE_W-1:0] cfg_data,
  input  logic                        accept,
  input  logic [7:0]                  src_byte,
  output logic                        job_valid,
  output cce_pkg::job_t               job
);
  import cce_pkg::*;

  logic [BSIZE_W-1:0] bsize;
  logic [CNT_W-1:0]   written_count;
  logic [CNT_W-1:0]   written_count_next;
  logic [CNT_W-1:0]   cap;
  logic               emit;

  always_comb begin
    if (bsize == '0) begin
      cap = '0;
    end else if (bsize > BSIZE_W'(MAX_BUFFER)) begin
      cap = CNT_W'(MAX_BUFFER - 1);
    end else begin
      cap = CNT_W'(bsize - BSIZE_W'(1));
    end
  end

  always_comb begin
    job                = '0;
    emit               = 1'b0;
    written_count_next = written_count;
    if (src_byte == CH_NUL) begin
      emit               = 1'b1;
      job.eos            = 1'b1;
      job.chars[0]       = CH_NUL;
      written_count_next = '0;
    end else if (written_count >= cap) begin
      emit = 1'b0;
    end else if (src_byte < CH_SPACE) begin
      emit         = 1'b1;
      job.chars[0] = CH_CARET;
      job.chars[1] = src_byte + CTRL_OFS;
      if ({1'b0, written_count} + (CNT_W+1)'(1) < {1'b0, cap}) begin
        job.last_idx       = 2'd1;
        written_count_next = written_count + CNT_W'(2);
      end else begin
        written_count_next = written_count + CNT_W'(1);
      end
    end else if (src_byte > CH_TILDE) begin
      if ({1'b0, written_count} + (CNT_W+1)'(ESC_LEN) < {1'b0, cap}) begin
        emit               = 1'b1;
        job.chars          = dec_digits(src_byte);
        job.last_idx       = 2'(ESC_LEN - 1);
        written_count_next = written_count + CNT_W'(ESC_LEN);
      end
    end else begin
      emit               = 1'b1;
      job.chars[0]       = src_byte;
      written_count_next = written_count + CNT_W'(1);
    end
  end

  assign job_valid = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      bsize         <= BSIZE_RESET;
      written_count <= '0;
    end else begin
      if (cfg_valid) begin
        bsize <= cfg_data;
      end
      if (accept) begin
        written_count <= written_count_next;
      end
    end
  end

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    accept && src_byte == CH_NUL |=> written_count == '0)
    else $error("written count not cleared by terminator");

endmodule

@@ sv/cce_queue.sv @@
// Short job queue between the front and back ends.
// Depends on cce_pkg for the job type and depth.
module cce_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  cce_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd,
  output cce_pkg::job_t rd_job,
  output logic          empty
);
  import cce_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] count;
  logic              do_wr;
  logic              do_rd;

  assign full   = count == QCNT_W'(QDEPTH);
  assign empty  = count == '0;
  assign do_wr  = wr && !full;
  assign do_rd  = rd && !empty;
  assign rd_job = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wp <= wp + QPTR_W'(1);
      end
      if (do_rd) begin
        rp <= rp + QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    !full && !empty |-> wp != rp)
    else $error("queue pointers disagree with count");

endmodule

@@ sv/cce_back.sv @@
// Back end: walks each queued job one character per cycle into an output register
// while the output is free or popped; depends on cce_pkg for the job type.
module cce_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  cce_pkg::job_t q_job,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_char,
  output logic          end_of_string,
  output logic          last_of_run
);
  import cce_pkg::*;

  logic       out_valid;
  logic [1:0] pos;
  logic       take;
  logic       at_last;

  assign empty   = !out_valid;
  assign take    = !q_empty && (!out_valid || pop);
  assign at_last = pos == q_job.last_idx;
  assign q_rd    = take && at_last;

  always_ff @(posedge clk) begin
    if (take) begin
      out_char      <= q_job.chars[pos];
      end_of_string <= q_job.eos;
      last_of_run   <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        pos       <= at_last ? 2'd0 : pos + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_eos_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_string |-> last_of_run && out_char == CH_NUL)
    else $error("terminator not marked as a lone result");

endmodule

@@ sv/control_char_escaper.sv @@
// An accepted byte's job is written into the job queue, then into the output register.
// Throughput: one output character per cycle while the output is free or popped; a byte
// expands to up to four characters on the back end (four for a decimal escape).
// Input stalls only when the four-entry job queue fills.
// Reset (rst, synchronous): queue and output empty, count zero, buffer_size 512.
module control_char_escaper (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [7:0]                  src_byte,
  input  logic                        pop,
  output logic                        empty,
  output logic [7:0]                  out_char,
  output logic                        end_of_string,
  output logic                        last_of_run,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cce_pkg::BSIZE_W-1:0] buffer_size
);
  import cce_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_rd;
  logic job_valid;
  job_t job;
  job_t q_job;

  assign full      = q_full;
  assign cfg_ready = 1'b1;

  cce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (buffer_size),
    .accept    (push && !q_full),
    .src_byte  (src_byte),
    .job_valid (job_valid),
    .job       (job)
  );

  cce_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (job_valid),
    .wr_job (job),
    .full   (q_full),
    .rd     (q_rd),
    .rd_job (q_job),
    .empty  (q_empty)
  );

  cce_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_job         (q_job),
    .q_rd          (q_rd),
    .pop           (pop),
    .empty         (empty),
    .out_char      (out_char),
    .end_of_string (end_of_string),
    .last_of_run   (last_of_run)
  );

endmodule
